// File: hw/rtl/sjq_pkg.sv
package sjq_pkg;

    localparam int ID_W  = 8;
    localparam int PRI_W = 8;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        STAT_ADDED   = 2'd0,
        STAT_REMOVED = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // apply the captured command to the list
    } t_ctrl;

endpackage

// File: hw/rtl/sjq_ctrl.sv
module sjq_ctrl
    import sjq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.exec = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ctrl.load = start;
            end
            ST_EXEC: begin
                busy        = 1'b1;
                o_ctrl.exec = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/sjq_datapath.sv
module sjq_datapath
    import sjq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl            i_ctrl,
    input  logic             i_command,
    input  logic [ID_W-1:0]  i_job_id,
    input  logic [PRI_W-1:0] i_priority_req,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [ID_W-1:0]  o_removed_id,
    output logic [PRI_W-1:0] o_removed_priority,
    output logic [OCC_W-1:0] o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Sorted entry cells, entry 0 is the front of the queue.
    logic [ID_W-1:0]  r_ids  [CAPACITY];
    logic [PRI_W-1:0] r_pris [CAPACITY];
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    t_cmd             r_cmd;
    logic [ID_W-1:0]  r_id;
    logic [PRI_W-1:0] r_pri;

    logic             w_full;
    logic             w_empty;
    logic             w_do_add;
    logic             w_do_remove;
    logic [CAPACITY-1:0] w_keep;

    t_status          n_status;
    logic [ID_W-1:0]  n_removed_id;
    logic [PRI_W-1:0] n_removed_priority;

    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_do_add    = i_ctrl.exec && (r_cmd == CMD_ADD) && !w_full;
    assign w_do_remove = i_ctrl.exec && (r_cmd == CMD_REMOVE) && !w_empty;

    // A cell keeps its job on an add when it is occupied and its priority
    // is at least the new one, so equal priorities stay first in, first out.
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_keep[k] = (CW'(k) < r_count) && (r_pris[k] >= r_pri);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= t_cmd'(i_command);
            r_id  <= i_job_id;
            r_pri <= i_priority_req;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_do_add && !w_keep[k]) begin
                if (k == 0 || w_keep[(k == 0) ? 0 : k - 1]) begin
                    r_ids[k]  <= r_id;
                    r_pris[k] <= r_pri;
                end else begin
                    r_ids[k]  <= r_ids[(k == 0) ? 0 : k - 1];
                    r_pris[k] <= r_pris[(k == 0) ? 0 : k - 1];
                end
            end else if (w_do_remove && k < CAPACITY - 1) begin
                r_ids[k]  <= r_ids[(k < CAPACITY - 1) ? k + 1 : k];
                r_pris[k] <= r_pris[(k < CAPACITY - 1) ? k + 1 : k];
            end
        end
    end

    always_comb begin
        n_count            = r_count;
        n_status           = STAT_ADDED;
        n_removed_id       = '0;
        n_removed_priority = '0;
        if (r_cmd == CMD_ADD) begin
            if (w_full) begin
                n_status = STAT_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = STAT_EMPTY;
            end else begin
                n_status           = STAT_REMOVED;
                n_removed_id       = r_ids[0];
                n_removed_priority = r_pris[0];
                n_count            = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_ctrl.exec;
            if (i_ctrl.exec) begin
                r_count <= n_count;
            end
        end
    end

    // The occupancy field carries the low bits of the job count.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            o_status           <= n_status;
            o_removed_id       <= n_removed_id;
            o_removed_priority <= n_removed_priority;
            o_occupancy        <= OCC_W'(n_count);
        end
    end

endmodule

// File: hw/rtl/sorted_priority_job_queue_top.sv
// Channel  | Direction | Handshake              | Word fields
// ---------+-----------+------------------------+---------------------------------------------
// command  | in        | start high, busy low   | i_command, i_job_id, i_priority_req
// result   | out       | o_done for one cycle   | o_status, o_removed_id,
//          |           |                        | o_removed_priority, o_occupancy
//
// Each command word is captured at the accepting edge, and during the
// following cycle (busy high) all cells compare their priority with the
// new one in parallel and shift in one step.
// The result word is registered at the end of that busy cycle, with o_done
// high for exactly one cycle; the receiver cannot stall it.
// A new word may be accepted in the same cycle that the result is shown,
// but not while the block is busy with the previous word.
// Reset is synchronous and active low; it empties the queue at once.
module sorted_priority_job_queue_top
    import sjq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_command,
    input  logic [ID_W-1:0]  i_job_id,
    input  logic [PRI_W-1:0] i_priority_req,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [ID_W-1:0]  o_removed_id,
    output logic [PRI_W-1:0] o_removed_priority,
    output logic [OCC_W-1:0] o_occupancy
);

    t_ctrl w_ctrl;

    // The controller sequences capture and execution of each word.
    sjq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctrl  (w_ctrl)
    );

    // The datapath holds the sorted cells, the job count and the result
    // register.
    sjq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctrl             (w_ctrl),
        .i_command          (i_command),
        .i_job_id           (i_job_id),
        .i_priority_req     (i_priority_req),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_removed_id       (o_removed_id),
        .o_removed_priority (o_removed_priority),
        .o_occupancy        (o_occupancy)
    );

endmodule

// File: hw/rtl/sjq_checker.sv
module sjq_checker
    import sjq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic [1:0]       o_status,
    input logic [ID_W-1:0]  o_removed_id,
    input logic [PRI_W-1:0] o_removed_priority,
    input logic [OCC_W-1:0] o_occupancy
);

    // An accepted word makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // Every busy cycle is followed by a result strobe with busy low.
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done && !busy)
        else $error("busy cycle not followed by a result");

    // A result strobe only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a command");

    // Only a removal reports a job.
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != STAT_REMOVED) |->
            (o_removed_id == '0) && (o_removed_priority == '0))
        else $error("removed fields set on a non-removal");

    // A remove on an empty queue reports zero occupancy.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == STAT_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with nonzero occupancy");

endmodule

bind sorted_priority_job_queue_top sjq_checker u_sjq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_status           (o_status),
    .o_removed_id       (o_removed_id),
    .o_removed_priority (o_removed_priority),
    .o_occupancy        (o_occupancy)
);
